// ----- hw/rtl/m68000_subset_execute_unit_assert.svh -----
// Assertion macros for the subset execute unit.
// Used by the top level; expects clk and rst_n in scope.
`ifndef M68000_SUBSET_EXECUTE_UNIT_ASSERT_SVH
`define M68000_SUBSET_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define MSX_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define MSX_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hw/rtl/msx_pkg.sv -----
// Shared types and constants of the subset execute unit.
// No dependencies.
`default_nettype none
package msx_pkg;

  localparam int QDEPTH = 2;

  localparam logic [15:0] OP_MOVEL = 16'h203c;
  localparam logic [15:0] OP_STORE = 16'h20c0;
  localparam logic [15:0] OP_MOVEW = 16'h303c;
  localparam logic [15:0] OP_SR    = 16'h46fc;
  localparam logic [15:0] OP_NOP   = 16'h4e70;
  localparam logic [15:0] OP_RTS   = 16'h4e75;
  localparam logic [15:0] OP_LEA   = 16'h4ff9;
  localparam logic [15:0] OP_DBRA  = 16'h51c8;
  localparam logic [15:0] OP_BSR   = 16'h6100;
  localparam logic [15:0] OP_SUBA  = 16'h91c8;
  localparam logic [15:0] OP_ADD   = 16'hd080;
  localparam logic [15:0] M_RX     = 16'hf1ff;
  localparam logic [15:0] M_RXRY   = 16'hf1f8;
  localparam logic [15:0] M_RY     = 16'hfff8;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic [1:0] DK_NONE = 2'd0;
  localparam logic [1:0] DK_DATA = 2'd1;
  localparam logic [1:0] DK_ADDR = 2'd2;
  localparam logic [1:0] DK_SR   = 2'd3;

  localparam logic CFG_START_PC    = 1'b0;
  localparam logic CFG_START_STACK = 1'b1;

  typedef enum logic [3:0] {
    K_MOVEL, K_STORE, K_MOVEW, K_SR, K_NOP, K_RTS, K_LEA,
    K_DBRA, K_BSR, K_SUBA, K_ADD, K_ILLEGAL, K_RESTART
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  rx;
    logic [2:0]  ry;
    logic [31:0] ext;
  } dec_t;

  typedef struct packed {
    logic [1:0] count;
    logic       full;
    logic       empty;
  } q_stat_t;

endpackage
`default_nettype wire

// ----- hw/rtl/msx_if.sv -----
// Request and response channel interfaces of the subset execute unit.
// No dependencies.
`default_nettype none
interface msx_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] opcode;
  logic [31:0] ext_bits;
  modport source (output valid, req_type, opcode, ext_bits, input ready);
  modport sink (input valid, req_type, opcode, ext_bits, output ready);
endinterface

interface msx_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic [1:0]  status;
  logic        write_valid;
  logic [31:0] write_addr;
  logic [31:0] write_data;
  logic [1:0]  dest_kind;
  logic [2:0]  dest_index;
  logic [31:0] dest_value;
  modport source (output valid, next_pc, status, write_valid, write_addr, write_data,
                  dest_kind, dest_index, dest_value, input ready);
  modport sink (input valid, next_pc, status, write_valid, write_addr, write_data,
                dest_kind, dest_index, dest_value, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/msx_front.sv -----
// Front end: accepts requests and classifies opcodes.
// Depends on msx_pkg and msx_req_if.
`default_nettype none
module msx_front (
  msx_req_if.sink       in_req,
  input  wire logic     q_full,
  output msx_pkg::dec_t dec,
  output logic          push
);
  import msx_pkg::*;

  logic [15:0] op;

  assign op = in_req.opcode;
  assign in_req.ready = !q_full;
  assign push = in_req.valid && !q_full;

  always_comb begin
    dec.rx  = op[11:9];
    dec.ry  = op[2:0];
    dec.ext = in_req.ext_bits;
    priority if (in_req.req_type)          dec.kind = K_RESTART;
    else if ((op & M_RX) == OP_MOVEL)      dec.kind = K_MOVEL;
    else if ((op & M_RXRY) == OP_STORE)    dec.kind = K_STORE;
    else if ((op & M_RX) == OP_MOVEW)      dec.kind = K_MOVEW;
    else if (op == OP_SR)                  dec.kind = K_SR;
    else if (op == OP_NOP)                 dec.kind = K_NOP;
    else if (op == OP_RTS)                 dec.kind = K_RTS;
    else if (op == OP_LEA)                 dec.kind = K_LEA;
    else if ((op & M_RY) == OP_DBRA)       dec.kind = K_DBRA;
    else if (op == OP_BSR)                 dec.kind = K_BSR;
    else if ((op & M_RY) == OP_SUBA)       dec.kind = K_SUBA;
    else if ((op & M_RXRY) == OP_ADD)      dec.kind = K_ADD;
    else                                   dec.kind = K_ILLEGAL;
  end
endmodule
`default_nettype wire

// ----- hw/rtl/msx_queue.sv -----
// Two-entry queue of decoded transactions between front and back.
// Depends on msx_pkg.
`default_nettype none
module msx_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire msx_pkg::dec_t  wdata,
  input  wire logic           pop,
  output msx_pkg::dec_t       head,
  output msx_pkg::q_stat_t    stat
);
  import msx_pkg::*;

  dec_t       ent_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign head = ent_r[rp_r];
  assign stat.count = cnt_r;
  assign stat.full  = (cnt_r == 2'(QDEPTH));
  assign stat.empty = (cnt_r == 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= wdata;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= !wp_r;
      if (pop) rp_r <= !rp_r;
      cnt_r <= cnt_nxt;
    end
  end
endmodule
`default_nettype wire

// ----- hw/rtl/msx_back.sv -----
// Back end: register file, byte-lane RAM and response register.
// Depends on msx_pkg and msx_rsp_if.
`default_nettype none
module msx_back #(
  parameter int RAM_BYTES = 65536
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [31:0]   cfg_wdata,
  input  wire msx_pkg::dec_t head,
  input  wire logic          head_valid,
  output logic               pop,
  msx_rsp_if.source          out_rsp
);
  import msx_pkg::*;

  localparam int LANE_DEPTH = RAM_BYTES / 4;
  localparam int AW = $clog2(LANE_DEPTH);
  localparam logic [32:0] RAM_LIMIT = 33'(RAM_BYTES);

  typedef enum logic [1:0] {S_EXEC = 2'b01, S_RDWAIT = 2'b10} state_t;

  state_t      state_r, state_nxt;
  logic [31:0] start_pc_r, start_stack_r;
  logic [31:0] dreg_r [8];
  logic [31:0] areg_r [8];
  logic [31:0] pc_r, pc_nxt;
  logic [15:0] sr_r;
  logic        halted_r;

  logic        out_valid_r;
  logic [31:0] o_npc_r, o_wa_r, o_wd_r, o_dv_r;
  logic [1:0]  o_st_r, o_dk_r;
  logic        o_wv_r;
  logic [2:0]  o_di_r;

  logic        free, go, out_load;
  logic [31:0] npc, wa, wd, dv;
  logic [1:0]  st, dk;
  logic        wv;
  logic [2:0]  di;
  logic        d_we, a_we, sr_we, set_halt, restart;
  logic [2:0]  d_idx, a_idx;
  logic [31:0] d_val, a_val;
  logic        acc_re;
  logic [31:0] acc_addr;
  logic [31:0] sext, ds, dx, ay, ax, a7, lwv;
  logic [15:0] lw;

  logic [7:0]  rbyte_r [4];
  logic [3:0]  rinr_r;
  logic [1:0]  ra_r;
  logic [31:0] rd_val;

  assign free = !out_valid_r || out_rsp.ready;
  assign go   = (state_r == S_EXEC) && head_valid && free;
  assign pop  = go;

  assign sext = {{16{head.ext[31]}}, head.ext[31:16]};
  assign ds   = dreg_r[head.ry];
  assign dx   = dreg_r[head.rx];
  assign ay   = areg_r[head.ry];
  assign ax   = areg_r[head.rx];
  assign a7   = areg_r[7];
  assign lw   = ds[15:0] - 16'd1;
  assign lwv  = {ds[31:16], lw};

  always_comb begin
    state_nxt = state_r;
    out_load = 1'b0;
    pc_nxt = pc_r;
    npc = pc_r; st = ST_DONE; wv = 1'b0; wa = '0; wd = '0;
    dk = DK_NONE; di = 3'd0; dv = '0;
    d_we = 1'b0; d_idx = head.rx; d_val = head.ext;
    a_we = 1'b0; a_idx = head.rx; a_val = '0;
    sr_we = 1'b0; set_halt = 1'b0; restart = 1'b0;
    acc_re = 1'b0; acc_addr = a7;
    unique case (state_r)
      S_EXEC: begin
        if (go) begin
          out_load = 1'b1;
          priority if (head.kind == K_RESTART) begin
            restart = 1'b1;
            npc = start_pc_r;
          end else if (halted_r) begin
            st = ST_IGNORED;
          end else begin
            unique case (head.kind)
              K_MOVEL: begin
                d_we = 1'b1; npc = pc_r + 32'd6;
                dk = DK_DATA; di = head.rx; dv = head.ext;
              end
              K_STORE: begin
                wv = 1'b1; wa = ax; wd = ds; acc_addr = ax;
                a_we = 1'b1; a_val = ax + 32'd4; npc = pc_r + 32'd2;
                dk = DK_ADDR; di = head.rx; dv = a_val;
              end
              K_MOVEW: begin
                d_we = 1'b1; d_val = {dx[31:16], head.ext[31:16]};
                npc = pc_r + 32'd4; dk = DK_DATA; di = head.rx; dv = d_val;
              end
              K_SR: begin
                sr_we = 1'b1; npc = pc_r + 32'd4;
                dk = DK_SR; dv = {16'd0, head.ext[31:16]};
              end
              K_NOP: npc = pc_r + 32'd2;
              K_RTS: begin
                out_load = 1'b0; acc_re = 1'b1; state_nxt = S_RDWAIT;
              end
              K_LEA: begin
                a_we = 1'b1; a_idx = 3'd7; a_val = head.ext; npc = pc_r + 32'd6;
                dk = DK_ADDR; di = 3'd7; dv = head.ext;
              end
              K_DBRA: begin
                d_we = 1'b1; d_idx = head.ry; d_val = lwv;
                npc = (lw != 16'hffff) ? pc_r + 32'd2 + sext : pc_r + 32'd4;
                dk = DK_DATA; di = head.ry; dv = lwv;
              end
              K_BSR: begin
                a_we = 1'b1; a_idx = 3'd7; a_val = a7 - 32'd4;
                wv = 1'b1; wa = a_val; wd = pc_r + 32'd4; acc_addr = a_val;
                npc = pc_r + 32'd2 + sext;
                dk = DK_ADDR; di = 3'd7; dv = a_val;
              end
              K_SUBA: begin
                a_we = 1'b1; a_idx = 3'd0; a_val = areg_r[0] - ay;
                npc = pc_r + 32'd2; dk = DK_ADDR; di = 3'd0; dv = a_val;
              end
              K_ADD: begin
                d_we = 1'b1; d_val = dx + ds; npc = pc_r + 32'd2;
                dk = DK_DATA; di = head.rx; dv = d_val;
              end
              default: begin
                set_halt = 1'b1; st = ST_HALT;
              end
            endcase
          end
          if (out_load) pc_nxt = npc;
        end
      end
      S_RDWAIT: begin
        if (free) begin
          out_load = 1'b1;
          a_we = 1'b1; a_idx = 3'd7; a_val = a7 + 32'd4;
          npc = rd_val; pc_nxt = rd_val;
          dk = DK_ADDR; di = 3'd7; dv = a_val;
          state_nxt = S_EXEC;
        end
      end
      default: state_nxt = S_EXEC;
    endcase
  end

  genvar gl;
  generate
    for (gl = 0; gl < 4; gl++) begin : g_lane
      logic [7:0]  mem [LANE_DEPTH];
      logic [1:0]  k;
      logic [31:0] baddr;
      logic        inr;
      logic [7:0]  wbyte;
      assign k     = 2'(gl) - acc_addr[1:0];
      assign baddr = acc_addr + {30'd0, k};
      assign inr   = {1'b0, baddr} < RAM_LIMIT;
      assign wbyte = 8'(wd >> {2'd3 - k, 3'b000});
      always_ff @(posedge clk) begin
        if (wv && inr) mem[baddr[AW+1:2]] <= wbyte;
        if (acc_re) begin
          rbyte_r[gl] <= mem[baddr[AW+1:2]];
          rinr_r[gl]  <= inr;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (acc_re) ra_r <= acc_addr[1:0];
  end

  always_comb begin
    logic [1:0] l;
    rd_val = '0;
    for (int b = 0; b < 4; b++) begin
      l = ra_r + 2'(b);
      rd_val[31-8*b -: 8] = rinr_r[l] ? rbyte_r[l] : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_npc_r <= npc; o_st_r <= st; o_wv_r <= wv; o_wa_r <= wa; o_wd_r <= wd;
      o_dk_r <= dk; o_di_r <= di; o_dv_r <= dv;
    end
    if (!rst_n) begin
      state_r <= S_EXEC;
      out_valid_r <= 1'b0;
      start_pc_r <= '0;
      start_stack_r <= '0;
      pc_r <= '0;
      sr_r <= '0;
      halted_r <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        dreg_r[i] <= '0;
        areg_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_rsp.ready) out_valid_r <= 1'b0;
      if (cfg_we && cfg_index == CFG_START_PC) start_pc_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_START_STACK) start_stack_r <= cfg_wdata;
      pc_r <= pc_nxt;
      if (restart) begin
        sr_r <= '0;
        halted_r <= 1'b0;
        for (int i = 0; i < 8; i++) begin
          dreg_r[i] <= '0;
          areg_r[i] <= (i == 7) ? start_stack_r : 32'd0;
        end
      end else begin
        if (set_halt) halted_r <= 1'b1;
        if (sr_we) sr_r <= head.ext[31:16];
        if (d_we) dreg_r[d_idx] <= d_val;
        if (a_we) areg_r[a_idx] <= a_val;
      end
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.next_pc     = o_npc_r;
  assign out_rsp.status      = o_st_r;
  assign out_rsp.write_valid = o_wv_r;
  assign out_rsp.write_addr  = o_wa_r;
  assign out_rsp.write_data  = o_wd_r;
  assign out_rsp.dest_kind   = o_dk_r;
  assign out_rsp.dest_index  = o_di_r;
  assign out_rsp.dest_value  = o_dv_r;
endmodule
`default_nettype wire

// ----- hw/rtl/m68000_subset_execute_unit.sv -----
// Top level of the 68000 subset execute unit.
// Depends on msx_pkg, msx_if, msx_front, msx_queue, msx_back and the assert header.
//
// channel   dir  handshake      payload
// in_req    in   valid/ready    req_type, opcode, ext_bits
// out_rsp   out  valid/ready    next_pc, status, write_*, dest_*
// cfg_*     in   cfg_we         cfg_index, cfg_wdata
//
// In the back end an executed rts passes through S_RDWAIT for its registered RAM read; all else completes in S_EXEC.
// Front and back are parted by a two-entry queue; results sit in an output register.
// Synchronous active-low reset clears registers, PC, SR and halt; RAM is not cleared.
// Stalls on out_rsp fill the queue, then drop in_req.ready.
`default_nettype none
module m68000_subset_execute_unit #(
  parameter int RAM_BYTES = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  msx_req_if.sink          in_req,
  msx_rsp_if.source        out_rsp,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_wdata
);
  import msx_pkg::*;

  dec_t    dec, head;
  logic    push, pop;
  q_stat_t qs;

  msx_front u_front (
    .in_req (in_req),
    .q_full (qs.full),
    .dec    (dec),
    .push   (push)
  );

  msx_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (dec),
    .pop   (pop),
    .head  (head),
    .stat  (qs)
  );

  msx_back #(.RAM_BYTES(RAM_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .head       (head),
    .head_valid (!qs.empty),
    .pop        (pop),
    .out_rsp    (out_rsp)
  );

`include "m68000_subset_execute_unit_assert.svh"

  `MSX_ASSERT_IMP(a_pop_nonempty, pop, qs.count != 2'd0)
  `MSX_ASSERT_IMP(a_ready_full, !in_req.ready, qs.count == 2'(QDEPTH))
  `MSX_ASSERT_NXT(a_push_grows, push && !pop, qs.count == $past(qs.count) + 2'd1)

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// Testbench for m68000_subset_execute_unit: random 68000-subset programs with a predictor.
// Depends on msx_pkg, msx_if and the execute unit RTL.
module tb;
  import msx_pkg::*;

  localparam int RAM_SIZE = 65536;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [1:0]  status;
    logic        write_valid;
    logic [31:0] write_addr;
    logic [31:0] write_data;
    logic [1:0]  dest_kind;
    logic [2:0]  dest_index;
    logic [31:0] dest_value;
  } result_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] opcode;
    logic [31:0] ext_bits;
  } instr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  msx_req_if in_req();
  msx_rsp_if out_rsp();

  m68000_subset_execute_unit i_dut (
    .clk(clk), .rst_n(rst_n), .in_req(in_req), .out_rsp(out_rsp),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predicted machine state
  logic [31:0] dreg [8];
  logic [31:0] areg [8];
  logic [31:0] pc_q;
  logic [15:0] sr_q;
  bit          halted_q;
  logic [31:0] start_pc_q, start_sp_q;
  logic [7:0]  ram [RAM_SIZE];
  bit          ram_written [RAM_SIZE];

  instr_t  pending_instrs[$];
  result_t expected_results[$];
  int      mismatches = 0;
  bit      no_idle = 1'b0;

  function automatic kind_t classify(logic [15:0] op);
    if ((op & M_RX) == OP_MOVEL) return K_MOVEL;
    if ((op & M_RXRY) == OP_STORE) return K_STORE;
    if ((op & M_RX) == OP_MOVEW) return K_MOVEW;
    if (op == OP_SR) return K_SR;
    if (op == OP_NOP) return K_NOP;
    if (op == OP_RTS) return K_RTS;
    if (op == OP_LEA) return K_LEA;
    if ((op & M_RY) == OP_DBRA) return K_DBRA;
    if (op == OP_BSR) return K_BSR;
    if ((op & M_RY) == OP_SUBA) return K_SUBA;
    if ((op & M_RXRY) == OP_ADD) return K_ADD;
    return K_ILLEGAL;
  endfunction

  function automatic logic [31:0] ram_read32(logic [31:0] a);
    logic [31:0] v;
    logic [31:0] b;
    v = '0;
    for (int i = 0; i < 4; i++) begin
      b = a + i;
      v = {v[23:0], (b < RAM_SIZE) ? ram[b[15:0]] : 8'h00};
    end
    return v;
  endfunction

  function automatic bit stack_readable(logic [31:0] a);
    logic [31:0] b;
    for (int i = 0; i < 4; i++) begin
      b = a + i;
      if (b < RAM_SIZE && !ram_written[b[15:0]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic ram_write32(logic [31:0] a, logic [31:0] v);
    logic [31:0] b;
    for (int i = 0; i < 4; i++) begin
      b = a + i;
      if (b < RAM_SIZE) begin
        ram[b[15:0]] = v[31 - 8 * i -: 8];
        ram_written[b[15:0]] = 1'b1;
      end
    end
  endtask

  function automatic logic [31:0] sext_word(logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction

  // advance the predicted state by one transaction and queue the expected result
  task automatic execute_instr(logic req, logic [15:0] op, logic [31:0] ext);
    result_t r;
    logic [2:0] rx, ry;
    logic [15:0] lw;
    instr_t it;
    rx = op[11:9];
    ry = op[2:0];
    r = '0;
    r.next_pc = pc_q;
    if (req) begin
      for (int i = 0; i < 8; i++) begin
        dreg[i] = '0;
        areg[i] = '0;
      end
      sr_q = '0;
      halted_q = 1'b0;
      areg[7] = start_sp_q;
      r.next_pc = start_pc_q;
    end else if (halted_q) begin
      r.status = ST_IGNORED;
    end else begin
      case (classify(op))
        K_MOVEL: begin
          dreg[rx] = ext;
          r.next_pc = pc_q + 6;
          r.dest_kind = DK_DATA; r.dest_index = rx; r.dest_value = dreg[rx];
        end
        K_STORE: begin
          r.write_valid = 1'b1; r.write_addr = areg[rx]; r.write_data = dreg[ry];
          ram_write32(areg[rx], dreg[ry]);
          areg[rx] = areg[rx] + 4;
          r.next_pc = pc_q + 2;
          r.dest_kind = DK_ADDR; r.dest_index = rx; r.dest_value = areg[rx];
        end
        K_MOVEW: begin
          dreg[rx][15:0] = ext[31:16];
          r.next_pc = pc_q + 4;
          r.dest_kind = DK_DATA; r.dest_index = rx; r.dest_value = dreg[rx];
        end
        K_SR: begin
          sr_q = ext[31:16];
          r.next_pc = pc_q + 4;
          r.dest_kind = DK_SR; r.dest_value = {16'h0, ext[31:16]};
        end
        K_NOP: r.next_pc = pc_q + 2;
        K_RTS: begin
          r.next_pc = ram_read32(areg[7]);
          areg[7] = areg[7] + 4;
          r.dest_kind = DK_ADDR; r.dest_index = 3'd7; r.dest_value = areg[7];
        end
        K_LEA: begin
          areg[7] = ext;
          r.next_pc = pc_q + 6;
          r.dest_kind = DK_ADDR; r.dest_index = 3'd7; r.dest_value = ext;
        end
        K_DBRA: begin
          lw = dreg[ry][15:0] - 16'd1;
          dreg[ry][15:0] = lw;
          r.next_pc = (lw != 16'hffff) ? pc_q + 2 + sext_word(ext[31:16]) : pc_q + 4;
          r.dest_kind = DK_DATA; r.dest_index = ry; r.dest_value = dreg[ry];
        end
        K_BSR: begin
          areg[7] = areg[7] - 4;
          r.write_valid = 1'b1; r.write_addr = areg[7]; r.write_data = pc_q + 4;
          ram_write32(areg[7], pc_q + 4);
          r.next_pc = pc_q + 2 + sext_word(ext[31:16]);
          r.dest_kind = DK_ADDR; r.dest_index = 3'd7; r.dest_value = areg[7];
        end
        K_SUBA: begin
          areg[0] = areg[0] - areg[ry];
          r.next_pc = pc_q + 2;
          r.dest_kind = DK_ADDR; r.dest_index = 3'd0; r.dest_value = areg[0];
        end
        K_ADD: begin
          dreg[rx] = dreg[rx] + dreg[ry];
          r.next_pc = pc_q + 2;
          r.dest_kind = DK_DATA; r.dest_index = rx; r.dest_value = dreg[rx];
        end
        default: begin
          halted_q = 1'b1;
          r.status = ST_HALT;
        end
      endcase
    end
    pc_q = r.next_pc;
    it.req_type = req;
    it.opcode = op;
    it.ext_bits = ext;
    pending_instrs.push_back(it);
    expected_results.push_back(r);
  endtask

  function automatic logic [31:0] stack_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return {16'h0, $urandom_range(16, 16383) * 4};
    if (r < 85) return 32'h10000 + $urandom_range(0, 16) - 8;
    return $urandom;
  endfunction

  function automatic logic [15:0] illegal_opcode();
    logic [15:0] op;
    do op = $urandom_range(0, 65535); while (classify(op) != K_ILLEGAL);
    return op;
  endfunction

  task automatic random_instr(kind_t k);
    logic [2:0] rx, ry;
    logic [31:0] ext;
    rx = $urandom_range(0, 7);
    ry = $urandom_range(0, 7);
    ext = $urandom;
    if (k == K_RTS && !stack_readable(areg[7])) k = K_BSR;
    case (k)
      K_MOVEL: execute_instr(1'b0, OP_MOVEL | {rx, 9'h0}, ext);
      K_STORE: execute_instr(1'b0, OP_STORE | {rx, 9'h0} | ry, ext);
      K_MOVEW: execute_instr(1'b0, OP_MOVEW | {rx, 9'h0}, ext);
      K_SR:    execute_instr(1'b0, OP_SR, ext);
      K_NOP:   execute_instr(1'b0, OP_NOP, ext);
      K_RTS:   execute_instr(1'b0, OP_RTS, ext);
      K_LEA:   execute_instr(1'b0, OP_LEA, stack_addr());
      K_DBRA:  execute_instr(1'b0, OP_DBRA | ry, ext);
      K_BSR:   execute_instr(1'b0, OP_BSR, ext);
      K_SUBA:  execute_instr(1'b0, OP_SUBA | ry, ext);
      K_ADD:   execute_instr(1'b0, OP_ADD | {rx, 9'h0} | ry, ext);
      K_RESTART: execute_instr(1'b1, $urandom_range(0, 65535), ext);
      default: begin
        execute_instr(1'b0, illegal_opcode(), ext);
        repeat ($urandom_range(0, 3)) execute_instr(1'b0, $urandom_range(0, 65535), $urandom);
        execute_instr(1'b1, $urandom_range(0, 65535), $urandom);
      end
    endcase
  endtask

  function automatic kind_t pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return K_MOVEL;
    if (r < 22) return K_STORE;
    if (r < 30) return K_MOVEW;
    if (r < 34) return K_SR;
    if (r < 37) return K_NOP;
    if (r < 47) return K_RTS;
    if (r < 54) return K_LEA;
    if (r < 64) return K_DBRA;
    if (r < 74) return K_BSR;
    if (r < 80) return K_SUBA;
    if (r < 93) return K_ADD;
    if (r < 96) return K_RESTART;
    return K_ILLEGAL;
  endfunction

  function automatic int idle_len();
    int r;
    if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic wait_idle();
    while (pending_instrs.size() != 0 || expected_results.size() != 0 || in_req.valid)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_START_PC) start_pc_q = val;
    else start_sp_q = val;
  endtask

  // driver
  logic in_fire = 1'b0;
  int   in_gap = 0;
  always @(posedge clk) in_fire <= rst_n && in_req.valid && in_req.ready;

  initial begin
    in_req.valid = 1'b0;
    in_req.req_type = 1'b0;
    in_req.opcode = '0;
    in_req.ext_bits = '0;
    out_rsp.ready = 1'b0;
  end

  always @(negedge clk) begin
    instr_t it;
    if (rst_n && (!in_req.valid || in_fire)) begin
      if (in_gap > 0) begin
        in_req.valid <= 1'b0;
        in_gap--;
      end else if (pending_instrs.size() != 0) begin
        it = pending_instrs.pop_front();
        in_req.valid <= 1'b1;
        in_req.req_type <= it.req_type;
        in_req.opcode <= it.opcode;
        in_req.ext_bits <= it.ext_bits;
        in_gap = idle_len();
      end else begin
        in_req.valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_stall = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_rsp.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_rsp.ready <= 1'b0;
      out_stall--;
    end else begin
      out_rsp.ready <= 1'b1;
      out_stall = idle_len();
    end
  end

  always @(posedge clk) begin
    result_t got, exp_r;
    if (rst_n && out_rsp.valid && out_rsp.ready) begin
      got = {out_rsp.next_pc, out_rsp.status, out_rsp.write_valid, out_rsp.write_addr,
             out_rsp.write_data, out_rsp.dest_kind, out_rsp.dest_index, out_rsp.dest_value};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] pcs [6];
    logic [31:0] sps [6];
    pcs = '{32'h0, 32'hffffffff, 32'h1000, 32'h0, 32'hfffffffe, 32'h0};
    sps = '{32'h0, 32'hffffffff, 32'h8000, 32'h10002, 32'h0, 32'hfff0};
    for (int i = 0; i < 8; i++) begin
      dreg[i] = '0;
      areg[i] = '0;
    end
    pc_q = '0;
    sr_q = '0;
    halted_q = 1'b0;
    start_pc_q = '0;
    start_sp_q = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: every instruction, stack pushes across and beyond the RAM end, halt
    write_cfg(CFG_START_PC, 32'h400);
    write_cfg(CFG_START_STACK, 32'h1000);
    execute_instr(1'b1, 16'h0, 32'h0);
    execute_instr(1'b0, OP_MOVEL | 16'h0e00, 32'hffffffff);
    execute_instr(1'b0, OP_MOVEW, 32'h8000ffff);
    execute_instr(1'b0, OP_ADD | 16'h0e00 | 16'h7, 32'h0);
    execute_instr(1'b0, OP_STORE | 16'h0200 | 16'h7, 32'h0);
    execute_instr(1'b0, OP_SR, 32'hffff0000);
    execute_instr(1'b0, OP_NOP, 32'hffffffff);
    execute_instr(1'b0, OP_BSR, 32'h7ffe0000);
    execute_instr(1'b0, OP_RTS, 32'h0);
    execute_instr(1'b0, OP_BSR, 32'h80000000);
    execute_instr(1'b0, OP_RTS, 32'h0);
    execute_instr(1'b0, OP_DBRA, 32'hfff00000);
    execute_instr(1'b0, OP_DBRA, 32'h00100000);
    execute_instr(1'b0, OP_DBRA | 16'h7, 32'h00100000);
    execute_instr(1'b0, OP_SUBA | 16'h7, 32'h0);
    execute_instr(1'b0, OP_LEA, 32'h10002);
    execute_instr(1'b0, OP_BSR, 32'h0);
    execute_instr(1'b0, OP_RTS, 32'h0);
    execute_instr(1'b0, OP_LEA, 32'h0);
    execute_instr(1'b0, OP_BSR, 32'h0);
    execute_instr(1'b0, OP_RTS, 32'h0);
    execute_instr(1'b0, 16'hffff, 32'h0);
    execute_instr(1'b0, OP_NOP, 32'h0);
    execute_instr(1'b1, 16'hffff, 32'hffffffff);
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_START_PC, pcs[ph]);
      write_cfg(CFG_START_STACK, sps[ph]);
      execute_instr(1'b1, 16'h0, 32'h0);
      repeat (125) random_instr(pick_kind());
      wait_idle();
    end

    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/msx_pkg.sv
hw/rtl/msx_if.sv
hw/rtl/msx_front.sv
hw/rtl/msx_queue.sv
hw/rtl/msx_back.sv
hw/rtl/m68000_subset_execute_unit.sv
test/tb.sv
